FILE: rtl/sofhdf_pkg.sv
// constants and types shared by the framing header deframer
`default_nettype none

package sofhdf_pkg;

    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned CNT_W        = 3;
    localparam int unsigned LEN_W        = 32;
    localparam int unsigned ENC_W        = 16;
    localparam int unsigned BODY_W       = 17;
    localparam int unsigned HIST_W       = 8 * (HEADER_BYTES - 1);

    localparam logic [ENC_W-1:0]  ENC_RESET = 16'hEB50;
    localparam logic [BODY_W-1:0] MAX_RESET = 17'(64 * 1024);

    // register indexes on the configuration port
    localparam logic REG_ENCODING = 1'b0;
    localparam logic REG_MAX_BODY = 1'b1;

    typedef enum logic [1:0] {
        REASON_ENCODING = 2'd0,
        REASON_SHORT    = 2'd1,
        REASON_LARGE    = 2'd2,
        REASON_LINK     = 2'd3
    } t_reason;

    typedef enum logic {
        KIND_BODY  = 1'b0,
        KIND_CLOSE = 1'b1
    } t_kind;

    typedef enum logic {
        MODE_DATA  = 1'b0,
        MODE_ERROR = 1'b1
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] body_byte;
        logic       body_last;
        t_reason    reason;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/sofh_stream_deframer_unit.sv
// output: a result is registered in the output register, or in the skid entry when a result already waits there
// throughput: one beat per cycle; a two-entry output register (result plus skid)
// keeps the input side open while one result waits, so the input stalls only when both are full
// reset: synchronous active-low; clears the phase, counters and output valids and
// sets expected encoding to 0xEB50 and the body limit to 65536 bytes
`default_nettype none

module sofh_stream_deframer_unit
    import sofhdf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire         s_axis_tuser,   // [0] mode
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] body_byte, [9:8] close_reason, rest zero
    output logic        m_axis_tlast,   // body_last
    output logic        m_axis_tuser,   // [0] out_kind
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_CLOSED = 2'd2
    } t_phase;

    logic [ENC_W-1:0]  r_enc;
    logic [BODY_W-1:0] r_max;

    t_phase            r_phase,  n_phase;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic [HIST_W-1:0] r_hist,   n_hist;
    logic [BODY_W-1:0] r_rem,    n_rem;

    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;

    logic              accept;
    logic              pop;
    logic              has_res;
    t_result           res;
    logic              cfg_wr;

    logic [LEN_W-1:0]  hdr_len;
    logic [ENC_W-1:0]  hdr_enc;
    logic [LEN_W-1:0]  hdr_body;
    logic [BODY_W-1:0] rem_dec;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_ENCODING: prdata = {{(32-ENC_W){1'b0}}, r_enc};
            default:      prdata = {{(32-BODY_W){1'b0}}, r_max};
        endcase
    end

    // the sixth header byte completes the encoding field
    assign hdr_len  = r_hist[HIST_W-1 -: LEN_W];
    assign hdr_enc  = {r_hist[7:0], s_axis_tdata};
    assign hdr_body = hdr_len - LEN_W'(HEADER_BYTES);
    assign rem_dec  = (r_rem == '0) ? '0 : r_rem - BODY_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_hist  = r_hist;
        n_rem   = r_rem;
        has_res = 1'b0;
        res     = '{kind: KIND_CLOSE, body_byte: 8'd0, body_last: 1'b0,
                    reason: REASON_LINK};
        if (r_phase == PH_HEADER || r_phase == PH_BODY) begin
            if (s_axis_tuser == MODE_ERROR) begin
                n_phase = PH_CLOSED;
                n_cnt   = '0;
                n_rem   = '0;
                has_res = 1'b1;
            end else if (r_phase == PH_HEADER) begin
                n_hist = {r_hist[HIST_W-9:0], s_axis_tdata};
                if (r_cnt == CNT_W'(HEADER_BYTES - 1)) begin
                    n_cnt = '0;
                    if (hdr_enc != r_enc) begin
                        n_phase    = PH_CLOSED;
                        has_res    = 1'b1;
                        res.reason = REASON_ENCODING;
                    end else if (hdr_len <= LEN_W'(HEADER_BYTES)) begin
                        n_phase    = PH_CLOSED;
                        has_res    = 1'b1;
                        res.reason = REASON_SHORT;
                    end else if (hdr_body > {{(LEN_W-BODY_W){1'b0}}, r_max}) begin
                        n_phase    = PH_CLOSED;
                        has_res    = 1'b1;
                        res.reason = REASON_LARGE;
                    end else begin
                        n_phase = PH_BODY;
                        n_rem   = hdr_body[BODY_W-1:0];
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end else begin
                n_rem   = rem_dec;
                has_res = 1'b1;
                res     = '{kind: KIND_BODY, body_byte: s_axis_tdata,
                            body_last: (rem_dec == '0), reason: REASON_ENCODING};
                if (rem_dec == '0) begin
                    n_phase = PH_HEADER;
                    n_cnt   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc   <= ENC_RESET;
            r_max   <= MAX_RESET;
            r_phase <= PH_HEADER;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_ENCODING: r_enc <= pwdata[ENC_W-1:0];
                    default:      r_max <= pwdata[BODY_W-1:0];
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_rem   <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist <= n_hist;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= accept && has_res;
            r_out       <= res;
        end else if (accept && has_res) begin
            r_skid_valid <= 1'b1;
            r_skid       <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.reason, r_out.body_byte};
    assign m_axis_tlast  = r_out.body_last;
    assign m_axis_tuser  = r_out.kind;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in front");

    a_closed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CLOSED |=> r_phase == PH_CLOSED)
        else $error("left the closed phase without reset");

    a_link_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser == MODE_ERROR && r_phase != PH_CLOSED)
        |=> r_phase == PH_CLOSED)
        else $error("link error did not close the connection");

    a_body_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_rem != '0)
        else $error("body phase with nothing left to deliver");

endmodule

`default_nettype wire
